>>> hw/rtl/pvm_pkg.sv
// Shared types and constants for the planar video memory block.
// Holds register indexes, mode codes and the configuration struct; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pvm_pkg;

  localparam int ADDR_W              = 16;
  localparam int DATA_W              = 8;
  localparam int PLANES              = 4;
  localparam int WORD_W              = PLANES * DATA_W;
  localparam int CFG_INDEX_W         = 3;
  localparam int CFG_DATA_W          = 8;
  localparam int DEFAULT_PLANE_DEPTH = 65536;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } pvm_op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WRITE_MODE       = 3'd0,
    REG_READ_MODE        = 3'd1,
    REG_LOGIC_FUNCTION   = 3'd2,
    REG_BIT_MASK         = 3'd3,
    REG_SET_RESET        = 3'd4,
    REG_ENABLE_SET_RESET = 3'd5,
    REG_READ_MAP_SELECT  = 3'd6,
    REG_MAP_MASK         = 3'd7
  } pvm_reg_t;

  typedef enum logic [1:0] {
    WM_SOURCE   = 2'd0,
    WM_LATCH    = 2'd1,
    WM_DATA_BIT = 2'd2,
    WM_LATCH_2  = 2'd3
  } pvm_wmode_t;

  typedef enum logic {
    RM_PLANE = 1'b0,
    RM_ZERO  = 1'b1
  } pvm_rmode_t;

  typedef enum logic [1:0] {
    LF_REPLACE = 2'd0,
    LF_AND     = 2'd1,
    LF_OR      = 2'd2,
    LF_XOR     = 2'd3
  } pvm_lfunc_t;

  typedef struct packed {
    pvm_wmode_t        write_mode;
    pvm_rmode_t        read_mode;
    pvm_lfunc_t        logic_function;
    logic [DATA_W-1:0] bit_mask;
    logic [PLANES-1:0] set_reset;
    logic [PLANES-1:0] enable_set_reset;
    logic [1:0]        read_map_select;
    logic [PLANES-1:0] map_mask;
  } pvm_cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/pvm_req_if.sv
// Request channel of the planar video memory: operation, address and write byte.
// Uses pvm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface pvm_req_if;
  import pvm_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input address, input write_data,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pvm_rsp_if.sv
// Response channel of the planar video memory: the byte returned by a read.
// Uses pvm_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none
interface pvm_rsp_if;
  import pvm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pvm_cfg_if.sv
// Configuration write channel of the planar video memory: register index and data.
// Uses pvm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface pvm_cfg_if;
  import pvm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/planar_video_memory_alu_core.sv
// Top level of the planar video memory with its graphics-controller datapath.
// Depends on pvm_pkg, the three channel interfaces, pvm_ram and pvm_write_alu.
//
// Four byte planes sit side by side in one PLANE_DEPTH x 32 RAM. After reset the block
// runs a clearing pass over all PLANE_DEPTH words, one word per cycle, and takes no
// request until it ends; configuration writes are taken at any time. A request is
// handled one at a time: two registered steps reduce the address modulo PLANE_DEPTH
// (a reciprocal multiply, then a multiply-back and subtract), then the ST_ACCESS state
// accesses the RAM, after which a write is done. A read adds the ST_CAPTURE state for
// the RAM's registered read, in which the latches are loaded and the byte is placed in
// the output register. A new request is taken while a read byte still waits, as long
// as the byte is taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module planar_video_memory_alu_core #(
  parameter int PLANE_DEPTH = pvm_pkg::DEFAULT_PLANE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  pvm_req_if.sink   req,
  pvm_rsp_if.source rsp,
  pvm_cfg_if.sink   cfg
);
  import pvm_pkg::*;

  localparam int AW = $clog2(PLANE_DEPTH);
  // The estimate floor(addr * RECIP / 2^32) is the true quotient or one less.
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / PLANE_DEPTH);
  localparam logic [AW:0] DEPTH_V = (AW + 1)'(PLANE_DEPTH);
  localparam logic [AW:0] LAST_V  = (AW + 1)'(PLANE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUOT,
    ST_REM,
    ST_ACCESS,
    ST_CAPTURE
  } state_t;

  state_t            state;
  pvm_cfg_t          cfg_q;
  logic [AW:0]       clr_cnt;
  logic              op;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] wdata;
  logic [ADDR_W-1:0] quot;
  logic [AW:0]       rem;
  logic [WORD_W-1:0] latches;
  logic              out_valid;
  logic [DATA_W-1:0] out_data;

  logic [48:0]       quot_prod;
  logic [32:0]       back_prod;
  logic [32:0]       rem_wide;
  logic [AW-1:0]     index;
  logic              ram_we;
  logic              ram_re;
  logic [PLANES-1:0] ram_be;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] alu_word;
  logic              req_fire;

  assign req.ready     = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign req_fire      = req.valid && req.ready;
  assign cfg.ready     = 1'b1;
  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  assign quot_prod = {33'd0, addr} * {16'd0, RECIP};
  assign back_prod = {17'd0, quot} * {{(32 - AW){1'b0}}, DEPTH_V};
  assign rem_wide  = {17'd0, addr} - back_prod;
  // The remainder estimate stays below twice the depth, so one correction is enough.
  assign index     = (rem >= DEPTH_V) ? AW'(rem - DEPTH_V) : rem[AW-1:0];

  pvm_write_alu u_alu (
    .cfg     (cfg_q),
    .latches (latches),
    .data    (wdata),
    .word    (alu_word)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_be    = '1;
    ram_addr  = index;
    ram_wdata = alu_word;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt[AW-1:0];
      ram_wdata = '0;
    end else if (state == ST_ACCESS) begin
      ram_we = (op == OP_WRITE);
      ram_re = (op == OP_READ);
      ram_be = cfg_q.map_mask;
    end
  end

  pvm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PLANE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .be    (ram_be),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      latches   <= '0;
      cfg_q     <= '{write_mode: WM_SOURCE, read_mode: RM_PLANE, logic_function: LF_REPLACE,
                     bit_mask: '1, set_reset: '0, enable_set_reset: '0,
                     read_map_select: '0, map_mask: '1};
    end else begin
      if (cfg.valid) begin
        unique case (pvm_reg_t'(cfg.index))
          REG_WRITE_MODE:       cfg_q.write_mode       <= pvm_wmode_t'(cfg.data[1:0]);
          REG_READ_MODE:        cfg_q.read_mode        <= pvm_rmode_t'(cfg.data[0]);
          REG_LOGIC_FUNCTION:   cfg_q.logic_function   <= pvm_lfunc_t'(cfg.data[1:0]);
          REG_BIT_MASK:         cfg_q.bit_mask         <= cfg.data[DATA_W-1:0];
          REG_SET_RESET:        cfg_q.set_reset        <= cfg.data[PLANES-1:0];
          REG_ENABLE_SET_RESET: cfg_q.enable_set_reset <= cfg.data[PLANES-1:0];
          REG_READ_MAP_SELECT:  cfg_q.read_map_select  <= cfg.data[1:0];
          REG_MAP_MASK:         cfg_q.map_mask         <= cfg.data[PLANES-1:0];
          default: ;
        endcase
      end

      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_V) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            op    <= req.operation;
            addr  <= req.address;
            wdata <= req.write_data;
            state <= ST_QUOT;
          end
        end
        ST_QUOT: begin
          quot  <= quot_prod[47:32];
          state <= ST_REM;
        end
        ST_REM: begin
          rem   <= rem_wide[AW:0];
          state <= ST_ACCESS;
        end
        ST_ACCESS: begin
          state <= (op == OP_READ) ? ST_CAPTURE : ST_IDLE;
        end
        ST_CAPTURE: begin
          // The output register is known to be empty here: a request is taken only
          // when it is empty or being emptied.
          latches   <= ram_rdata;
          out_valid <= 1'b1;
          out_data  <= (cfg_q.read_mode == RM_PLANE) ?
                       ram_rdata[{cfg_q.read_map_select, 3'b000} +: DATA_W] : '0;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pvm_ram.sv
// Generic single-port RAM with byte write enables and a registered read.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [WIDTH/8-1:0]       be,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  localparam int BYTES = WIDTH / 8;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int b = 0; b < BYTES; b++) begin
        if (be[b]) begin
          mem[addr][b*8 +: 8] <= wdata[b*8 +: 8];
        end
      end
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pvm_write_alu.sv
// Graphics-controller write datapath: source select, logic function and bit mask per plane.
// Uses pvm_pkg for the configuration struct and mode codes.
`timescale 1ns / 1ps
`default_nettype none
module pvm_write_alu (
  input  wire pvm_pkg::pvm_cfg_t          cfg,
  input  wire logic [pvm_pkg::WORD_W-1:0] latches,
  input  wire logic [pvm_pkg::DATA_W-1:0] data,
  output logic      [pvm_pkg::WORD_W-1:0] word
);
  import pvm_pkg::*;

  always_comb begin
    logic [DATA_W-1:0] latch;
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] alu;
    for (int p = 0; p < PLANES; p++) begin
      latch = latches[p*DATA_W +: DATA_W];
      if (cfg.write_mode == WM_DATA_BIT) begin
        src = {DATA_W{data[p]}};
      end else if (cfg.enable_set_reset[p]) begin
        src = {DATA_W{cfg.set_reset[p]}};
      end else begin
        src = data;
      end
      case (cfg.logic_function)
        LF_AND:  alu = src & latch;
        LF_OR:   alu = src | latch;
        LF_XOR:  alu = src ^ latch;
        default: alu = src;
      endcase
      case (cfg.write_mode) inside
        WM_LATCH, WM_LATCH_2: word[p*DATA_W +: DATA_W] = latch;
        default: word[p*DATA_W +: DATA_W] = (alu & cfg.bit_mask) | (latch & ~cfg.bit_mask);
      endcase
    end
  end

endmodule
`default_nettype wire
